[src/dzr_pkg.sv]
`timescale 1ns / 1ps
// Shared sizes, types and helpers of the diagonal zigzag reorder block.
package dzr_pkg;

	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLS    = 8;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

	localparam int DATA_W      = 32;
	localparam int CFG_W       = 4;
	localparam int CFG_IDX_W   = 2;

	localparam int ROW_IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_IDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_SIZE_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_SIZE_W  = $clog2(MAX_COLS + 1);
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int PROD_W      = ROW_IDX_W + COL_SIZE_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_USED = 2'd0,
		REG_COLS_USED = 2'd1
	} cfg_reg_t;

	// One read request of the scan sequencer toward the element store.
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} scan_req_t;

	// A zero size counts as one; sizes above the maximum saturate.
	function automatic logic [ROW_SIZE_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
		if (v == '0)
			return ROW_SIZE_W'(1);
		else if (int'(v) > MAX_ROWS)
			return ROW_SIZE_W'(MAX_ROWS);
		else
			return ROW_SIZE_W'(v);
	endfunction

	function automatic logic [COL_SIZE_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
		if (v == '0)
			return COL_SIZE_W'(1);
		else if (int'(v) > MAX_COLS)
			return COL_SIZE_W'(MAX_COLS);
		else
			return COL_SIZE_W'(v);
	endfunction

endpackage

[src/dzr_store.sv]
`timescale 1ns / 1ps
// Element store: one write port and one registered read port.
module dzr_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [dzr_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [dzr_pkg::DATA_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [dzr_pkg::ADDR_W-1:0]  rd_addr,
	output logic [dzr_pkg::DATA_W-1:0]  rd_data
);

	logic [dzr_pkg::DATA_W-1:0] mem_q [dzr_pkg::STORE_DEPTH];
	logic [dzr_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/dzr_scan.sv]
`timescale 1ns / 1ps
// Zigzag diagonal scan sequencer: walks the matrix and issues one store read a cycle.
module dzr_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [dzr_pkg::ROW_SIZE_W-1:0]   rows,
	input  logic [dzr_pkg::COL_SIZE_W-1:0]   cols,
	output dzr_pkg::scan_req_t               req
);

	logic                            active_q;
	logic                            up_q;
	logic [dzr_pkg::ROW_IDX_W-1:0]   row_q;
	logic [dzr_pkg::COL_IDX_W-1:0]   col_q;
	logic [dzr_pkg::ROW_IDX_W-1:0]   last_r;
	logic [dzr_pkg::COL_IDX_W-1:0]   last_c;
	logic [dzr_pkg::PROD_W-1:0]      lin_addr;
	logic                            at_end;

	assign last_r   = dzr_pkg::ROW_IDX_W'(rows - dzr_pkg::ROW_SIZE_W'(1));
	assign last_c   = dzr_pkg::COL_IDX_W'(cols - dzr_pkg::COL_SIZE_W'(1));
	assign at_end   = (row_q == last_r) && (col_q == last_c);
	assign lin_addr = dzr_pkg::PROD_W'(row_q) * dzr_pkg::PROD_W'(cols)
		+ dzr_pkg::PROD_W'(col_q);

	assign req.valid = active_q;
	assign req.addr  = dzr_pkg::ADDR_W'(lin_addr);
	assign req.last  = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			up_q     <= 1'b1;
			row_q    <= '0;
			col_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			up_q     <= 1'b1;
			row_q    <= '0;
			col_q    <= '0;
		end else if (active_q) begin
			if (at_end) begin
				active_q <= 1'b0;
				up_q     <= 1'b1;
				row_q    <= '0;
				col_q    <= '0;
			end else if (up_q) begin
				if (col_q == last_c) begin
					row_q <= row_q + 1'b1;
					up_q  <= 1'b0;
				end else if (row_q == '0) begin
					col_q <= col_q + 1'b1;
					up_q  <= 1'b0;
				end else begin
					row_q <= row_q - 1'b1;
					col_q <= col_q + 1'b1;
				end
			end else begin
				if (row_q == last_r) begin
					col_q <= col_q + 1'b1;
					up_q  <= 1'b1;
				end else if (col_q == '0) begin
					row_q <= row_q + 1'b1;
					up_q  <= 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
					col_q <= col_q - 1'b1;
				end
			end
		end
	end

endmodule

[src/diagonal_zigzag_reorder.sv]
`timescale 1ns / 1ps
// Top level of the diagonal zigzag reorder block.
//
// The block loads a rows_used by cols_used matrix one element per request, in
// row-major order, and then plays it back in zigzag diagonal order. A load
// request is accepted when start is high and busy is low; it writes the
// element into a single-port-write, registered-read element store. The
// request that completes the matrix starts the scan: in the next cycle the
// sequencer begins to issue one store read per cycle, and because the read
// data is registered each result appears in the cycle after its read,
// marked by scan_valid for exactly one cycle. The receiver cannot stall the
// stream, so it must take one result per cycle. busy stays high from the
// cycle after the completing request until the cycle after the result
// marked by scan_last. A zero size register reads as one and a value above
// the maximum saturates; writes to indexes beyond the register list are
// dropped. Sizes are meant to be written while the block is idle.
module diagonal_zigzag_reorder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [dzr_pkg::DATA_W-1:0]  element_value,
	output logic                               scan_valid,
	output logic signed [dzr_pkg::DATA_W-1:0]  scan_value,
	output logic                               scan_last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dzr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dzr_pkg::CFG_W-1:0]          cfg_data
);

	// Size registers hold the clamped values so the datapath never sees zero.
	logic [dzr_pkg::ROW_SIZE_W-1:0] rows_q;
	logic [dzr_pkg::COL_SIZE_W-1:0] cols_q;
	logic [dzr_pkg::CNT_W-1:0]      load_count_q;
	logic                           valid_s1;
	logic                           last_s1;

	logic [dzr_pkg::CNT_W-1:0]      total;
	logic [dzr_pkg::CNT_W-1:0]      count_inc;
	logic                           accept;
	logic                           complete;
	logic [dzr_pkg::DATA_W-1:0]     rd_data;
	dzr_pkg::scan_req_t             req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= dzr_pkg::ROW_SIZE_W'(dzr_pkg::MAX_ROWS);
			cols_q <= dzr_pkg::COL_SIZE_W'(dzr_pkg::MAX_COLS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dzr_pkg::REG_ROWS_USED: begin
					rows_q <= dzr_pkg::clamp_rows(cfg_data);
				end
				dzr_pkg::REG_COLS_USED: begin
					cols_q <= dzr_pkg::clamp_cols(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// Loading. The count before a load never exceeds the store depth minus one,
	// since the scan fires and clears it once it reaches the element count.
	assign accept    = start && !busy;
	assign total     = dzr_pkg::CNT_W'(rows_q) * dzr_pkg::CNT_W'(cols_q);
	assign count_inc = load_count_q + dzr_pkg::CNT_W'(1);
	assign complete  = accept && (count_inc >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (complete) begin
			load_count_q <= '0;
		end else if (accept) begin
			load_count_q <= count_inc;
		end
	end

	dzr_store u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (dzr_pkg::ADDR_W'(load_count_q)),
		.wr_data (element_value),
		.rd_en   (req.valid),
		.rd_addr (req.addr),
		.rd_data (rd_data)
	);

	// The scan starts the cycle after the completing write, so its first read
	// already sees that element and no forwarding path is needed.
	dzr_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (complete),
		.rows   (rows_q),
		.cols   (cols_q),
		.req    (req)
	);

	// One stage lines the strobe and last mark up with the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			last_s1  <= req.valid && req.last;
		end
	end

	assign busy       = req.valid || valid_s1;
	assign scan_valid = valid_s1;
	assign scan_value = rd_data;
	assign scan_last  = last_s1;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && req.valid))
		else $error("element store written while the scan reads it");

	a_addr_in_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> (dzr_pkg::CNT_W'(req.addr) < total))
		else $error("scan address beyond the matrix");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		scan_last |=> !busy)
		else $error("block still busy after the final result");

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		scan_last |-> scan_valid)
		else $error("last mark without a result strobe");

endmodule

[verif/diagonal_zigzag_reorder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the diagonal zigzag reorder block.
//
// Load requests wait in a queue that the stimulus process fills. A driver
// presents them at the falling clock edge, with random idle cycles whose
// density changes from phase to phase. A monitor at the rising edge sees
// each accepted request and feeds it to a scan-order predictor. The predictor
// keeps its own copy of the element store, the load count and the size
// registers. When a request completes the matrix, it lists every element in
// zigzag diagonal order. Each result strobe of the block is then compared
// with the oldest listed element. Size registers are written only while the
// block is idle, and the monitor mirrors every accepted write.
module diagonal_zigzag_reorder_tb;

	localparam int CLK_HALF   = 2;
	localparam int RESET_CYC  = 7;
	localparam int DRAIN_CYC  = 8;
	localparam int CYCLE_CAP  = 100000;
	localparam int RAND_ITEMS = 150;

	// Register indexes past the end of the list; the block must drop them.
	localparam logic [dzr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [dzr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		logic [dzr_pkg::DATA_W-1:0] value;
		logic                       last;
	} scan_item_t;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic signed [dzr_pkg::DATA_W-1:0] element_value;
	logic                              scan_valid;
	logic signed [dzr_pkg::DATA_W-1:0] scan_value;
	logic                              scan_last;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [dzr_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [dzr_pkg::CFG_W-1:0]         cfg_data;

	// Load requests not yet accepted, and scan results not yet seen.
	logic [dzr_pkg::DATA_W-1:0] element_queue[$];
	scan_item_t                 scan_expect[$];

	// Predictor state, mirrored from accepted requests and register writes.
	logic [dzr_pkg::DATA_W-1:0] mirror_store[dzr_pkg::STORE_DEPTH];
	int                         mirror_fill;
	logic [dzr_pkg::CFG_W-1:0]  mirror_rows;
	logic [dzr_pkg::CFG_W-1:0]  mirror_cols;

	int idle_pct;
	int error_count;
	int cfg_writes;
	int cycle_count;

	diagonal_zigzag_reorder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.scan_valid   (scan_valid),
		.scan_value   (scan_value),
		.scan_last    (scan_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// A zero size counts as one, anything past the maximum saturates.
	function automatic int size_clamp(input logic [dzr_pkg::CFG_W-1:0] v, input int maxv);
		if (v == '0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	// Stores one element in row-major order. When the element count reaches
	// the current matrix size, the whole matrix is walked in zigzag diagonal
	// order: up-right first, turning at every edge, and each visited element
	// becomes an expected result. The bottom-right element carries the last
	// mark and loading starts over at element zero.
	task automatic absorb_element(input logic [dzr_pkg::DATA_W-1:0] v);
		int         rows;
		int         cols;
		int         r;
		int         c;
		int         n;
		bit         up;
		bit         at_end;
		bit         done;
		scan_item_t item;
		rows = size_clamp(mirror_rows, dzr_pkg::MAX_ROWS);
		cols = size_clamp(mirror_cols, dzr_pkg::MAX_COLS);
		if (mirror_fill < dzr_pkg::STORE_DEPTH)
			mirror_store[mirror_fill] = v;
		mirror_fill++;
		if (mirror_fill < rows * cols)
			return;
		r = 0;
		c = 0;
		n = 0;
		up = 1'b1;
		done = 1'b0;
		while (!done) begin
			at_end = (r == rows - 1) && (c == cols - 1);
			item.value = mirror_store[r * cols + c];
			item.last = at_end;
			scan_expect.insert(scan_expect.size(), item);
			n++;
			if (at_end || n >= dzr_pkg::STORE_DEPTH) begin
				done = 1'b1;
			end else if (up) begin
				if (c == cols - 1) begin
					r++;
					up = 1'b0;
				end else if (r == 0) begin
					c++;
					up = 1'b0;
				end else begin
					r--;
					c++;
				end
			end else begin
				if (r == rows - 1) begin
					c++;
					up = 1'b1;
				end else if (c == 0) begin
					r++;
					up = 1'b1;
				end else begin
					r++;
					c--;
				end
			end
		end
		mirror_fill = 0;
	endtask

	// Driver: the front request is offered at the falling edge unless this
	// cycle is chosen to idle. While start is low the data lines carry noise.
	// A request offered while busy is high simply stays offered until taken.
	always @(negedge clk) begin
		if (arst_n && element_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
			start <= 1'b1;
			element_value <= element_queue[0];
		end else begin
			start <= 1'b0;
			element_value <= $urandom;
		end
	end

	// Monitor: results are checked before a request accepted at the same edge
	// can add expectations, since a scan never overlaps the next load.
	always @(posedge clk) begin
		if (arst_n) begin
			if (scan_valid) begin
				if (scan_expect.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual value %h last %b",
						$time, scan_value, scan_last);
					error_count++;
				end else begin
					if (scan_value !== scan_expect[0].value) begin
						$display("%0t: scan_value: expected %h, actual %h",
							$time, scan_expect[0].value, scan_value);
						error_count++;
					end
					if (scan_last !== scan_expect[0].last) begin
						$display("%0t: scan_last: expected %b, actual %b",
							$time, scan_expect[0].last, scan_last);
						error_count++;
					end
					void'(scan_expect.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dzr_pkg::REG_ROWS_USED: begin
						mirror_rows = cfg_data;
					end
					dzr_pkg::REG_COLS_USED: begin
						mirror_cols = cfg_data;
					end
					default: begin
					end
				endcase
				cfg_writes++;
			end
			if (start && !busy && element_queue.size() > 0) begin
				void'(element_queue.pop_front());
				absorb_element(element_value);
			end
		end
	end

	// The run is cut off if the block stops answering.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// One register write request, held until the monitor sees it taken.
	task automatic write_reg(input logic [dzr_pkg::CFG_IDX_W-1:0] idx,
		input logic [dzr_pkg::CFG_W-1:0] data);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(negedge clk);
		while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_size(input logic [dzr_pkg::CFG_W-1:0] rows,
		input logic [dzr_pkg::CFG_W-1:0] cols);
		write_reg(dzr_pkg::REG_ROWS_USED, rows);
		write_reg(dzr_pkg::REG_COLS_USED, cols);
	endtask

	// Waits until every request is taken, every result has come and busy is
	// low, then lets the block's pipeline empty before a register changes.
	// Checked at the falling edge, after all rising-edge updates have landed.
	task automatic settle();
		while (!(element_queue.size() == 0 && scan_expect.size() == 0 && !busy))
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Element values lean toward the extremes of the two's complement range.
	function automatic logic [dzr_pkg::DATA_W-1:0] pick_element();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Sizes are mostly small, with zero and maximum or oversize values now and then.
	function automatic logic [dzr_pkg::CFG_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return dzr_pkg::CFG_W'($urandom_range(15, 8));
		return dzr_pkg::CFG_W'($urandom_range(4, 1));
	endfunction

	// Appends one load request at the back of the pending queue.
	task automatic queue_element(input logic [dzr_pkg::DATA_W-1:0] v);
		element_queue.insert(element_queue.size(), v);
	endtask

	task automatic push_elements(input int count);
		for (int i = 0; i < count; i++)
			queue_element(pick_element());
	endtask

	int idle_plan[4] = '{0, 74, 0, 30};

	initial begin
		int phase_items;
		int total;
		int count;
		logic [dzr_pkg::CFG_W-1:0] rows_w;
		logic [dzr_pkg::CFG_W-1:0] cols_w;
		arst_n = 1'b0;
		start = 1'b0;
		element_value = '0;
		cfg_valid = 1'b0;
		cfg_index = dzr_pkg::REG_ROWS_USED;
		cfg_data = '0;
		idle_pct = 0;
		error_count = 0;
		cfg_writes = 0;
		cycle_count = 0;
		mirror_fill = 0;
		mirror_rows = dzr_pkg::CFG_W'(dzr_pkg::MAX_ROWS);
		mirror_cols = dzr_pkg::CFG_W'(dzr_pkg::MAX_COLS);
		for (int i = 0; i < dzr_pkg::STORE_DEPTH; i++)
			mirror_store[i] = '0;
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part. A one by one matrix answers every request with a
		// single last-marked result; the extreme values go through it.
		set_size(4'd1, 4'd1);
		queue_element(32'h8000_0000);
		queue_element(32'h7fff_ffff);
		settle();

		// A small rectangle shows the turns at the top and the right edge.
		set_size(4'd2, 4'd3);
		queue_element(32'h0000_0000);
		queue_element(32'hffff_ffff);
		queue_element(32'h0000_0001);
		queue_element(32'h8000_0000);
		queue_element(32'h7fff_ffff);
		queue_element(32'h5555_5555);
		settle();

		// Zero sizes must behave as one by one.
		set_size(4'd0, 4'd0);
		queue_element(32'haaaa_aaaa);
		settle();

		// An oversize row count saturates to a single full column. Writes
		// to indexes past the register list must leave the sizes alone.
		set_size(4'd15, 4'd1);
		write_reg(REG_SPARE_LO, 4'd3);
		write_reg(REG_SPARE_HI, 4'd2);
		push_elements(dzr_pkg::MAX_ROWS);
		settle();

		// A size shrunk in the middle of a load: the count already exceeds
		// the new size, so the next element completes the smaller matrix.
		set_size(4'd3, 4'd3);
		push_elements(5);
		settle();
		set_size(4'd2, 4'd2);
		push_elements(1);
		settle();

		// Random part, one idling density per phase.
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_plan[phase];
			phase_items = 0;
			while (phase_items < RAND_ITEMS / 4) begin
				if (phase == 1 && phase_items == 0) begin
					// One full-size matrix under heavy sender idling.
					settle();
					set_size(4'd15, 4'd15);
				end else if ($urandom_range(99) < 60) begin
					settle();
					rows_w = pick_size();
					cols_w = pick_size();
					if ($urandom_range(99) < 10)
						write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
							dzr_pkg::CFG_W'($urandom));
					set_size(rows_w, cols_w);
				end
				// Otherwise the size stays and the next matrix follows at once.
				total = size_clamp(mirror_rows, dzr_pkg::MAX_ROWS)
					* size_clamp(mirror_cols, dzr_pkg::MAX_COLS);
				count = total;
				// Some loads stop short, so the next size change lands mid-load.
				if ($urandom_range(99) < 12)
					count = $urandom_range(total - 1, 0);
				push_elements(count);
				phase_items += count;
			end
		end

		settle();
		repeat (DRAIN_CYC) @(negedge clk);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
